>>> hdl/laq_pkg.sv
// Package for the linear array queue: depth, operation and status codes,
// request and response item types, controller states. No dependencies.
`default_nettype none

package laq_pkg;

    localparam int DEPTH  = 16;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_SHOW = 2'd2,
        OP_PEEK = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } rsp_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_STREAM = 1'b1
    } state_t;

endpackage

`default_nettype wire

>>> hdl/linear_array_queue.sv
// Top level of the linear array queue: pointer control, read streaming and
// the response register. Depends on laq_pkg and laq_ram.
//
// Linear (non-circular) queue of DEPTH signed 32-bit words held in a
// synchronous slot memory with registered read data. Each request item
// carries an operation: enqueue, dequeue, display or peek. Enqueue stores the
// word after the rear and answers with the stored word; once the rear sits at
// the last slot every enqueue reports overflow, even if the front has moved
// on, until the queue drains (both pointers go back to slot 0 when the last
// word is dequeued). Dequeue, peek and display on an empty queue report
// underflow with zero data. Timing: enqueue and all error responses reach the
// response register in the cycle after the request is taken. Dequeue and peek
// first pass through the stream state, where the slot memory read is registered
// before the word reaches the response register. Display first reads the
// front slot and then streams one word per cycle while the response register
// is not stalled, front to rear, with last set on the rear word. A new request
// is taken only while the controller is idle and the response register is
// empty or being emptied in that cycle. Output stalls simply hold the stream;
// the memory read address is held so the read data stays valid.
`default_nettype none

module linear_array_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire laq_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output laq_pkg::rsp_t      rsp
);
    import laq_pkg::*;

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    state_t          state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [AW-1:0]   tail_reg, tail_next;
    logic            empty_reg, empty_next;
    logic [AW-1:0]   cur_reg, cur_next;
    logic [AW-1:0]   end_reg, end_next;
    logic            rsp_valid_reg, rsp_valid_next;
    rsp_t            rsp_reg, rsp_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic load;
    logic accept;
    logic stream_start;
    logic stream_end;

    laq_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Response register may take a new item when empty or being drained.
    assign load      = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE) || !load;
    assign accept    = req_valid && !req_stall;

    // Reads of held words go through the stream state; enqueue and errors do not.
    assign stream_start = accept && (req.op != OP_ENQ) && !empty_reg;
    assign stream_end   = load && (cur_reg == end_reg);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (stream_start)
                begin
                    state_next = ST_STREAM;
                end
            end
            ST_STREAM:
            begin
                if (stream_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        cur_next       = cur_reg;
        end_next       = end_reg;
        wr_en          = 1'b0;
        wr_addr        = tail_reg;
        wr_data        = req.value;
        rd_addr        = head_reg;
        rsp_valid_next = load ? 1'b0 : rsp_valid_reg;
        rsp_next       = rsp_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // Single-result requests are answered here; reads are
                    // answered from the stream state.
                    rsp_valid_next  = !stream_start;
                    rsp_next.last   = 1'b1;
                    rsp_next.status = STAT_OK;
                    rsp_next.data   = req.value;
                    if (req.op == OP_ENQ)
                    begin
                        if (empty_reg)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b0;
                        end
                        else if (tail_reg == LAST_SLOT)
                        begin
                            rsp_next.status = STAT_OVERFLOW;
                            rsp_next.data   = '0;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_addr   = tail_reg + 1'b1;
                            tail_next = tail_reg + 1'b1;
                        end
                    end
                    else if (empty_reg)
                    begin
                        rsp_next.status = STAT_UNDERFLOW;
                        rsp_next.data   = '0;
                    end
                    else
                    begin
                        // Stream from the front; display runs to the rear.
                        cur_next = head_reg;
                        end_next = head_reg;
                        case (req.op)
                            OP_SHOW:
                            begin
                                end_next = tail_reg;
                            end
                            OP_DEQ:
                            begin
                                if (head_reg == tail_reg)
                                begin
                                    head_next  = '0;
                                    tail_next  = '0;
                                    empty_next = 1'b1;
                                end
                                else
                                begin
                                    head_next = head_reg + 1'b1;
                                end
                            end
                            default:
                            begin
                                end_next = head_reg;
                            end
                        endcase
                    end
                end
            end
            ST_STREAM:
            begin
                // Hold the read address while stalled so the read data stays put.
                rd_addr = cur_reg;
                if (load)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next.status = STAT_OK;
                    rsp_next.data   = rd_data;
                    rsp_next.last   = (cur_reg == end_reg);
                    if (cur_reg != end_reg)
                    begin
                        cur_next = cur_reg + 1'b1;
                        rd_addr  = cur_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                rd_addr = head_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            cur_reg       <= '0;
            end_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            cur_reg       <= cur_next;
            end_reg       <= end_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload needs no reset.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire

>>> hdl/laq_ram.sv
// Slot store of the linear array queue: one write port, one read port,
// registered read data. Depends on laq_pkg.
`default_nettype none

module laq_ram (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [laq_pkg::AW-1:0]     wr_addr,
    input  wire logic [laq_pkg::DATA_W-1:0] wr_data,
    input  wire logic [laq_pkg::AW-1:0]     rd_addr,
    output logic      [laq_pkg::DATA_W-1:0] rd_data
);
    import laq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> sim/tb_linear_array_queue.sv
// Self-checking testbench for linear_array_queue: directed table then biased random requests,
// checked item by item against a behavioural mirror of the queue, under random stalls.
// Depends on laq_pkg and the linear_array_queue RTL only.
`timescale 1ns / 100ps

module tb_linear_array_queue;

    import laq_pkg::*;

    localparam int   HOLD_CYCLES = 80;   // length of the long receiver hold-off
    localparam int   RANDOM_ITEMS = 245;
    localparam rsp_t EMPTY_RSP = '{status: STAT_UNDERFLOW, data: '0, last: 1'b1};
    localparam rsp_t FULL_RSP  = '{status: STAT_OVERFLOW,  data: '0, last: 1'b1};

    // One row of the directed table. A pinned row carries its reply typed in by hand;
    // every other row is left to the mirror.
    typedef struct {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
        bit                       any_value;   // draw a fresh random word on each repeat
        int                       repeats;
        bit                       pinned;
        rsp_t                     pin;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // Hand-typed reply travelling alongside the request it belongs to.
    bit   pin_valid;
    rsp_t pin_rsp;

    // Behavioural mirror of the queue and the replies it still owes.
    logic signed [DATA_W-1:0] mirror_slots [DEPTH];
    int   mirror_front = 0;
    int   mirror_rear  = 0;
    bit   mirror_empty = 1'b1;
    rsp_t owed_replies [$];

    int   fails = 0;
    int   items_taken = 0;
    int   replies_seen = 0;
    int   overflows_seen = 0;
    int   underflows_seen = 0;
    int   longest_show = 0;
    int   burst_left = 0;
    bit   hold_request = 1'b0;

    linear_array_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic rsp_t word_rsp(logic signed [DATA_W-1:0] w, logic is_last);
        word_rsp = '{status: STAT_OK, data: w, last: is_last};
    endfunction

    // Advance the mirror by one request and queue up every reply it causes.
    function automatic void predict_replies(req_t r);
        int i;
        if (r.op == OP_ENQ)
        begin
            if (mirror_empty)
            begin
                // An empty queue always restarts at slot 0.
                mirror_front    = 0;
                mirror_rear     = 0;
                mirror_slots[0] = r.value;
                mirror_empty    = 1'b0;
                owed_replies.push_back(word_rsp(r.value, 1'b1));
            end
            else if (mirror_rear >= DEPTH - 1)
            begin
                // Rear at the last slot: refuse, however far the front has moved.
                owed_replies.push_back(FULL_RSP);
            end
            else
            begin
                mirror_rear++;
                mirror_slots[mirror_rear] = r.value;
                owed_replies.push_back(word_rsp(r.value, 1'b1));
            end
        end
        else if (mirror_empty)
        begin
            owed_replies.push_back(EMPTY_RSP);
        end
        else
        begin
            case (r.op)
                OP_DEQ:
                begin
                    owed_replies.push_back(word_rsp(mirror_slots[mirror_front], 1'b1));
                    if (mirror_front >= mirror_rear)
                    begin
                        // Last word gone: both indices drop back to slot 0.
                        mirror_front = 0;
                        mirror_rear  = 0;
                        mirror_empty = 1'b1;
                    end
                    else
                    begin
                        mirror_front++;
                    end
                end
                OP_PEEK:
                begin
                    owed_replies.push_back(word_rsp(mirror_slots[mirror_front], 1'b1));
                end
                default:
                begin
                    for (i = mirror_front; i <= mirror_rear; i++)
                        owed_replies.push_back(word_rsp(mirror_slots[i], i == mirror_rear));
                    if (mirror_rear - mirror_front + 1 > longest_show)
                        longest_show = mirror_rear - mirror_front + 1;
                end
            endcase
        end
    endfunction

    // Sample both channels at the rising edge: predict on every request taken,
    // then compare every reply taken with the oldest one owed.
    always @(posedge clk)
    begin : scoreboard
        rsp_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                items_taken++;
                predict_replies(req);
                // A hand-typed reply replaces the mirror's single prediction for this item.
                if (pin_valid)
                    owed_replies[owed_replies.size() - 1] = pin_rsp;
            end
            if (rsp_valid && !rsp_stall)
            begin
                replies_seen++;
                if (owed_replies.size() == 0)
                begin
                    $error("unexpected reply: status %0d data %0d last %0b",
                           rsp.status, rsp.data, rsp.last);
                    fails++;
                end
                else
                begin
                    want = owed_replies.pop_front();
                    if (want.status == STAT_OVERFLOW)
                        overflows_seen++;
                    if (want.status == STAT_UNDERFLOW)
                        underflows_seen++;
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        fails++;
                    end
                    if (rsp.data !== want.data)
                    begin
                        $error("data: expected %0d, got %0d", want.data, rsp.data);
                        fails++;
                    end
                    if (rsp.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, rsp.last);
                        fails++;
                    end
                end
            end
        end
    end

    // Receiver: stall on a pattern of its own, switching between free running,
    // light and heavy stalling. On request, hold off once for a long counted stretch.
    initial
    begin : reply_sink
        int mode;
        int mode_left;
        int hold_left;
        bit hold_done;
        rsp_stall = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                    default: rsp_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    // Offer one item at the falling edge and hold it until it is taken.
    task automatic offer(op_t op, logic signed [DATA_W-1:0] w, bit pinned, rsp_t pin);
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= '{op: op, value: w};
        pin_valid <= pinned;
        pin_rsp   <= pin;
        do @(posedge clk); while (req_stall);
    endtask

    // Sender pacing: keep offering within a burst, drop valid for a random gap between bursts.
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // Bias 0 fills the queue towards overflow, bias 1 drains it, bias 2 is plain noise.
    function automatic op_t pick_op(int bias);
        int r;
        r = $urandom_range(0, 99);
        case (bias)
            0:       pick_op = (r < 75) ? OP_ENQ : (r < 85) ? OP_DEQ :
                               (r < 93) ? OP_PEEK : OP_SHOW;
            1:       pick_op = (r < 70) ? OP_DEQ : (r < 85) ? OP_ENQ :
                               (r < 93) ? OP_PEEK : OP_SHOW;
            default: pick_op = (r < 25) ? OP_ENQ : (r < 50) ? OP_DEQ :
                               (r < 75) ? OP_PEEK : OP_SHOW;
        endcase
    endfunction

    // Mostly full-range words, with the signed extremes, zero and minus one mixed in.
    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       pick_word = 32'h8000_0000;
            1:       pick_word = 32'h7FFF_FFFF;
            2:       pick_word = 32'h0000_0000;
            3:       pick_word = 32'hFFFF_FFFF;
            default: pick_word = $urandom;
        endcase
    endfunction

    initial
    begin : stimulus
        plan_row_t plan [17];
        int n;
        int bias;
        int bias_left;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        pin_valid = 1'b0;
        pin_rsp   = '0;

        // Directed table: empty-queue errors, enqueue on empty then dequeue of the
        // only word, the signed extremes, a fill to the last slot, overflow, a full
        // display, and overflow again after the front has moved on.
        plan = '{
            '{OP_DEQ,  32'h0000_0000, 1'b0, 1,  1'b1, EMPTY_RSP},
            '{OP_PEEK, 32'hFFFF_FFFF, 1'b0, 1,  1'b1, EMPTY_RSP},
            '{OP_SHOW, 32'h0000_0000, 1'b0, 1,  1'b1, EMPTY_RSP},
            '{OP_ENQ,  32'h0000_0001, 1'b0, 1,  1'b1, word_rsp(32'h0000_0001, 1'b1)},
            '{OP_DEQ,  32'h0000_0000, 1'b0, 1,  1'b1, word_rsp(32'h0000_0001, 1'b1)},
            '{OP_PEEK, 32'h0000_0000, 1'b0, 1,  1'b1, EMPTY_RSP},
            '{OP_ENQ,  32'h8000_0000, 1'b0, 1,  1'b1, word_rsp(32'h8000_0000, 1'b1)},
            '{OP_ENQ,  32'h7FFF_FFFF, 1'b0, 1,  1'b1, word_rsp(32'h7FFF_FFFF, 1'b1)},
            '{OP_ENQ,  32'h0000_0000, 1'b0, 1,  1'b1, word_rsp(32'h0000_0000, 1'b1)},
            '{OP_ENQ,  32'hFFFF_FFFF, 1'b0, 1,  1'b1, word_rsp(32'hFFFF_FFFF, 1'b1)},
            '{OP_ENQ,  32'h0000_0000, 1'b1, 12, 1'b0, '0},
            '{OP_ENQ,  32'h1234_5678, 1'b0, 1,  1'b1, FULL_RSP},
            '{OP_SHOW, 32'h0000_0000, 1'b0, 1,  1'b0, '0},
            '{OP_PEEK, 32'h0000_0000, 1'b0, 1,  1'b1, word_rsp(32'h8000_0000, 1'b1)},
            '{OP_DEQ,  32'h0000_0000, 1'b0, 1,  1'b1, word_rsp(32'h8000_0000, 1'b1)},
            '{OP_DEQ,  32'h0000_0000, 1'b0, 1,  1'b1, word_rsp(32'h7FFF_FFFF, 1'b1)},
            '{OP_ENQ,  32'h0000_0005, 1'b0, 1,  1'b1, FULL_RSP}
        };

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[row])
        begin
            for (n = 0; n < plan[row].repeats; n++)
            begin
                offer(plan[row].op, plan[row].any_value ? pick_word() : plan[row].value,
                      plan[row].pinned, plan[row].pin);
                pace();
            end
        end

        // Random part: phases of filling, draining and noise, so the queue keeps
        // hitting both overflow and the drain back to slot 0.
        bias_left = 0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (bias_left == 0)
            begin
                bias      = $urandom_range(0, 2);
                bias_left = $urandom_range(8, 40);
            end
            bias_left--;
            // Long receiver hold-off while items keep coming: the block must back up.
            if (n == 40)
                hold_request = 1'b1;
            // Pause the sender until every owed reply has arrived.
            if (n == 150)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                while (owed_replies.size() != 0) @(posedge clk);
            end
            offer(pick_op(bias), pick_word(), 1'b0, '0);
            pace();
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (owed_replies.size() != 0) @(posedge clk);
        // Allow a full display stream worth of cycles for any stray reply to show up.
        repeat (2 * DEPTH + 8) @(posedge clk);

        $display("Run covered %0d requests and %0d replies (%0d overflow, %0d underflow).",
                 items_taken, replies_seen, overflows_seen, underflows_seen);
        $display("Longest display streamed %0d words; one receiver hold-off of %0d cycles.",
                 longest_show, HOLD_CYCLES);
        if (fails == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin : watchdog
        #(12 * 300_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> filelist.f
hdl/laq_pkg.sv
hdl/laq_ram.sv
hdl/linear_array_queue.sv
sim/tb_linear_array_queue.sv
